[design/rpq_pkg.sv]
// ----------------------------------------------------------------------------
// rpq_pkg: shared types and functions for the RGB palette quantizer
// Holds the palette mode codes, the result record and the per-channel
// quantizing functions used by the datapath.
// ----------------------------------------------------------------------------
package rpq_pkg;

    localparam int unsigned ChanWidth = 8;
    localparam int unsigned LumaWidth = 15;

    typedef logic [ChanWidth-1:0] chan_t;
    typedef logic [LumaWidth-1:0] luma_t;

    typedef enum logic [1:0] {
        MODE_MONO    = 2'd0,
        MODE_SIXTEEN = 2'd1,
        MODE_CUBE    = 2'd2,
        MODE_GRAY    = 2'd3
    } palette_mode_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        chan_t index;
    } rpq_result_t;

    localparam luma_t MonoThreshold = 15'd12800;

    localparam chan_t LevelZero = 8'h00;
    localparam chan_t LevelHalf = 8'h80;
    localparam chan_t LevelFull = 8'hff;
    localparam chan_t LevelLow  = 8'h55;
    localparam chan_t LevelHigh = 8'haa;

    // Luma scaled by 100: 30*r + 59*g + 11*b.
    function automatic luma_t luma100(input chan_t r, input chan_t g, input chan_t b);
        logic [LumaWidth-1:0] rr;
        logic [LumaWidth-1:0] gg;
        logic [LumaWidth-1:0] bb;
        rr = LumaWidth'(r) * LumaWidth'(30);
        gg = LumaWidth'(g) * LumaWidth'(59);
        bb = LumaWidth'(b) * LumaWidth'(11);
        return rr + gg + bb;
    endfunction

    // Division by 100 as a multiplication by a reciprocal; exact for all luma values.
    function automatic chan_t luma_div100(input luma_t l);
        logic [27:0] prod;
        prod = 28'(l) * 28'd5243;
        return prod[26:19];
    endfunction

    function automatic chan_t level3(input chan_t c);
        chan_t q;
        if (c < LevelLow) begin
            q = LevelZero;
        end else if (c < LevelHigh) begin
            q = LevelHalf;
        end else begin
            q = LevelFull;
        end
        return q;
    endfunction

    // Nearest multiple of 51, returned as the step number 0..5.
    function automatic logic [2:0] rb_step(input chan_t c);
        logic [2:0] s;
        s = 3'd0;
        if (c >= 8'd26)  s = 3'd1;
        if (c >= 8'd77)  s = 3'd2;
        if (c >= 8'd128) s = 3'd3;
        if (c >= 8'd179) s = 3'd4;
        if (c >= 8'd230) s = 3'd5;
        return s;
    endfunction

    // Nearest multiple of 42, returned as the step number 0..6.
    function automatic logic [2:0] g_step(input chan_t c);
        logic [2:0] s;
        s = 3'd0;
        if (c >= 8'd21)  s = 3'd1;
        if (c >= 8'd63)  s = 3'd2;
        if (c >= 8'd105) s = 3'd3;
        if (c >= 8'd147) s = 3'd4;
        if (c >= 8'd189) s = 3'd5;
        if (c >= 8'd231) s = 3'd6;
        return s;
    endfunction

endpackage

[design/rpq_quant.sv]
// ----------------------------------------------------------------------------
// rpq_quant: palette quantizing datapath
// Maps one registered pixel to its palette colour and index for the
// selected palette mode.
// ----------------------------------------------------------------------------
module rpq_quant
    import rpq_pkg::*;
(
    input  palette_mode_t mode,
    input  chan_t         red,
    input  chan_t         green,
    input  chan_t         blue,
    output rpq_result_t   result
);

    luma_t      luma;
    chan_t      gray;
    chan_t      qr;
    chan_t      qg;
    chan_t      qb;
    logic       any_full;
    logic       any_half;
    logic [2:0] rs;
    logic [2:0] gs;
    logic [2:0] bs;

    assign luma = luma100(red, green, blue);
    assign gray = luma_div100(luma);
    assign qr   = level3(red);
    assign qg   = level3(green);
    assign qb   = level3(blue);
    assign rs   = rb_step(red);
    assign gs   = g_step(green);
    assign bs   = rb_step(blue);

    assign any_full = (qr == LevelFull) || (qg == LevelFull) || (qb == LevelFull);
    assign any_half = (qr == LevelHalf) || (qg == LevelHalf) || (qb == LevelHalf);

    always_comb
    begin
        result = '0;
        case (mode)
            MODE_MONO:
            begin
                if (luma < MonoThreshold) begin
                    result = '0;
                end else begin
                    result.red   = LevelFull;
                    result.green = LevelFull;
                    result.blue  = LevelFull;
                    result.index = 8'd1;
                end
            end
            MODE_SIXTEEN:
            begin
                result.red   = (any_full && qr == LevelHalf) ? LevelZero : qr;
                result.green = (any_full && qg == LevelHalf) ? LevelZero : qg;
                result.blue  = (any_full && any_half && qb == LevelHalf) ? LevelZero : qb;
                result.index = 8'd0;
            end
            MODE_CUBE:
            begin
                result.red   = 8'(rs) * 8'd51;
                result.green = 8'(gs) * 8'd42;
                result.blue  = 8'(bs) * 8'd51;
                result.index = 8'(bs) * 8'd42 + 8'(gs) * 8'd6 + 8'(rs);
            end
            MODE_GRAY:
            begin
                result.red   = gray;
                result.green = gray;
                result.blue  = gray;
                result.index = gray;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

endmodule

[design/rgb_palette_quantizer.sv]
// ----------------------------------------------------------------------------
// rgb_palette_quantizer: RGB pixel to fixed palette quantizer
// Takes one pixel per transaction and returns its palette colour and index.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall, red_in, green_in, blue_in) takes one
// pixel per transaction. The output channel (out_valid, out_stall, red_out,
// green_out, blue_out, palette_index) returns exactly one result for each
// pixel, in order.
// The palette is chosen by the configuration channel (cfg_valid, cfg_ready,
// cfg_data): 0 mono, 1 sixteen colour, 2 cube, 3 gray ramp. cfg_ready is
// always high; the mode should only be changed while no pixel is in flight.
// A pixel passes an input register and then a result register, with the
// quantizing logic between the two registers. One pixel is accepted
// every cycle while in_stall is low.
// Reset empties both registers and sets the mode to mono. When the receiver
// stalls, the result holds; the input register still fills, and in_stall
// rises only when both registers are full and the output is stalled.
// ----------------------------------------------------------------------------
module rgb_palette_quantizer
    import rpq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] red_in,
    input  logic [7:0] green_in,
    input  logic [7:0] blue_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] red_out,
    output logic [7:0] green_out,
    output logic [7:0] blue_out,
    output logic [7:0] palette_index,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data
);

    palette_mode_t mode_reg;
    logic          in_valid_reg;
    chan_t         red_reg;
    chan_t         green_reg;
    chan_t         blue_reg;
    logic          out_valid_reg;
    rpq_result_t   result_reg;
    rpq_result_t   result_next;
    logic          adv_out;
    logic          adv_in;

    assign adv_out   = !out_valid_reg || !out_stall;
    assign adv_in    = !in_valid_reg || adv_out;
    assign in_stall  = !adv_in;
    assign cfg_ready = 1'b1;

    rpq_quant u_quant (
        .mode   (mode_reg),
        .red    (red_reg),
        .green  (green_reg),
        .blue   (blue_reg),
        .result (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg      <= MODE_MONO;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                mode_reg <= palette_mode_t'(cfg_data);
            end
            if (adv_in) begin
                in_valid_reg <= in_valid;
            end
            if (adv_out) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_in && in_valid) begin
            red_reg   <= red_in;
            green_reg <= green_in;
            blue_reg  <= blue_in;
        end
        if (adv_out && in_valid_reg) begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign red_out       = result_reg.red;
    assign green_out     = result_reg.green;
    assign blue_out      = result_reg.blue;
    assign palette_index = result_reg.index;

endmodule

[design/rpq_checker.sv]
// ----------------------------------------------------------------------------
// rpq_checker: port-level checks for the RGB palette quantizer
// Watches the channels of the top level and is bound to it.
// ----------------------------------------------------------------------------
module rpq_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] red_out,
    input logic [7:0] green_out,
    input logic [7:0] blue_out,
    input logic [7:0] palette_index,
    input logic       cfg_ready
);

    // The input side is held back only when a finished result is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("in_stall raised without a stalled result");

    // An input transaction followed by a free output cycle gives a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
        else $error("accepted pixel did not reach the output");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result was dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(red_out) && $stable(green_out)
            && $stable(blue_out) && $stable(palette_index)))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind rgb_palette_quantizer rpq_checker u_rpq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .red_out       (red_out),
    .green_out     (green_out),
    .blue_out      (blue_out),
    .palette_index (palette_index),
    .cfg_ready     (cfg_ready)
);
